/* src/rwl2_pkg.sv */
// Package for the two-writer-class readers-writer lock manager.
// Holds action, status and state codes and default sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rwl2_pkg;

   localparam int MaxThreadsDefault = 8;
   localparam int QueueDepthDefault = 8;
   localparam int ThreadIdWidth     = 3;

   typedef enum logic [3:0] {
      ACT_ENQ_READER  = 4'd0,
      ACT_ENQ_WRITER1 = 4'd1,
      ACT_ENQ_WRITER2 = 4'd2,
      ACT_ACQ_READER  = 4'd3,
      ACT_ACQ_WRITER1 = 4'd4,
      ACT_ACQ_WRITER2 = 4'd5,
      ACT_UNLOCK      = 4'd6,
      ACT_INIT        = 4'd7,
      ACT_DESTROY     = 4'd8
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_REFUSED    = 2'd1,
      ST_FULL       = 2'd2,
      ST_NOT_HOLDER = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_READER  = 2'd1,
      MODE_WRITER1 = 2'd2,
      MODE_WRITER2 = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

   // Control from the sequencer to the reader holder list.
   typedef struct packed {
      logic clear_scan;
      logic step_scan;
      logic add;
      logic shift;
   } hold_ctrl_type;

endpackage
`default_nettype wire

/* src/rwl2_holders.sv */
// Reader holder list: an ordered array with a shared compare unit that
// scans one entry per cycle and a shift step that closes a removed slot.
// Depends on rwl2_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rwl2_holders
   import rwl2_pkg::*;
#(
   parameter int MAX_THREADS = MaxThreadsDefault
) (
   input  wire                      clock,
   input  wire                      reset,
   input  hold_ctrl_type            ctrl,
   input  wire [ThreadIdWidth-1:0]  tid,
   output logic [$clog2(MAX_THREADS+1)-1:0] count,
   output logic                     full,
   output logic                     scan_done,
   output logic                     scan_hit,
   output logic                     scan_last
);
   localparam int CW = $clog2(MAX_THREADS+1);
   localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

   logic [ThreadIdWidth-1:0] list_ff [MAX_THREADS];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;

   assign count = count_ff;
   assign full  = (count_ff >= CW'(MAX_THREADS));
   // The shared compare unit looks at the entry under the scan pointer.
   assign scan_done = (idx_ff >= count_ff);
   assign scan_hit  = !scan_done && (list_ff[idx_ff[IW-1:0]] == tid);
   // The slot after the scan pointer lies past the end of the list.
   assign scan_last = (idx_ff + CW'(1) >= count_ff);

   // Scan pointer and count.
   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      if (ctrl.clear_scan) idx_in = '0;
      else if (ctrl.step_scan) idx_in = idx_ff + CW'(1);
      else if (ctrl.shift) begin
         if (idx_ff + CW'(1) >= count_ff) count_in = count_ff - CW'(1);
         else idx_in = idx_ff + CW'(1);
      end
      if (ctrl.add) count_in = count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   // Entry storage: append at the tail or move one entry down.
   always_ff @(posedge clock) begin
      if (ctrl.add) list_ff[count_ff[IW-1:0]] <= tid;
      else if (ctrl.shift && (idx_ff + CW'(1) < count_ff))
         list_ff[idx_ff[IW-1:0]] <= list_ff[IW'(idx_ff + CW'(1))];
   end
endmodule
`default_nettype wire

/* src/rwl2_fifo.sv */
// Small thread-id FIFO with front compare, used for class and arrival queues.
// Depends on rwl2_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rwl2_fifo
   import rwl2_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire                     pop,
   input  wire [ThreadIdWidth-1:0] din,
   output logic                    full,
   output logic                    not_empty,
   output logic                    front_match
);
   localparam int CW = $clog2(QUEUE_DEPTH+1);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [ThreadIdWidth-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] head_ff, tail_ff;
   logic [CW-1:0] count_ff;

   assign full        = (count_ff >= CW'(QUEUE_DEPTH));
   assign not_empty   = (count_ff != '0);
   assign front_match = not_empty && (mem_ff[head_ff] == din);

   // Pointers wrap at the depth, which need not be a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) tail_ff <= (tail_ff == PW'(QUEUE_DEPTH-1)) ? '0 : tail_ff + PW'(1);
         if (pop)  head_ff <= (head_ff == PW'(QUEUE_DEPTH-1)) ? '0 : head_ff + PW'(1);
         if (push && !pop) count_ff <= count_ff + CW'(1);
         else if (pop && !push) count_ff <= count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[tail_ff] <= din;
   end
endmodule
`default_nettype wire

/* src/rw_lock_two_writer_classes_unit.sv */
// Top level of the readers-writer lock manager with two writer classes.
// Depends on rwl2_pkg, rwl2_fifo and rwl2_holders.
//
// Each request beat yields one response beat. Enqueue, acquire, writer
// unlock, init and destroy are decided in S_SCAN, and the response beat is
// then presented in S_RESP. Unlock of a reader hold walks the holder list
// one entry per cycle through a single comparator and then closes the gap one
// entry per cycle in S_SHIFT before the response. After the response beat is
// taken the block returns to S_IDLE, where it is ready again. The request
// side is not ready while an item is in work or its response waits. The user
// must write preference_mode on csr_ only while idle; the block itself does
// not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module rw_lock_two_writer_classes_unit
   import rwl2_pkg::*;
#(
   parameter int MAX_THREADS = MaxThreadsDefault,
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [1:0]  csr_data,          // preference_mode
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,         // [3:0] action, [6:4] thread_id
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [15:0] rsp_tdata         // [1:0] status, [2] writer1_held,
                                         // [3] writer2_held, [7:4] reader_count,
                                         // [8] readers_waiting,
                                         // [9] writer1_waiting,
                                         // [10] writer2_waiting,
                                         // [11] lock_destroyed
);
   localparam int CW = $clog2(MAX_THREADS+1);

   state_type state_ff, state_in;
   logic [3:0] act_ff;
   logic [ThreadIdWidth-1:0] tid_ff;
   status_type status_ff, status_in;
   logic [1:0] mode_ff;
   logic w1_ff, w2_ff, destroyed_ff;
   logic [ThreadIdWidth-1:0] w1_id_ff, w2_id_ff;

   logic [2:0] fpush, fpop, ffull, fne, fmatch;
   logic apush, apop, afull, ane, amatch;
   hold_ctrl_type hctrl;
   logic [CW-1:0] hcount;
   logic hfull, hdone, hhit, hlast;

   logic is_enq, is_acq, grant, accept_req;
   logic [1:0] cls;
   logic [1:0] mode;

   assign mode = mode_ff;
   assign accept_req = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Class queues and the shared arrival queue.
   for (genvar g = 0; g < 3; g++) begin : g_cls
      rwl2_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
         .clock, .reset, .push(fpush[g]), .pop(fpop[g]), .din(tid_ff),
         .full(ffull[g]), .not_empty(fne[g]), .front_match(fmatch[g]));
   end
   rwl2_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_arrival (
      .clock, .reset, .push(apush), .pop(apop), .din(tid_ff),
      .full(afull), .not_empty(ane), .front_match(amatch));

   rwl2_holders #(.MAX_THREADS(MAX_THREADS)) u_holders (
      .clock, .reset, .ctrl(hctrl), .tid(tid_ff), .count(hcount),
      .full(hfull), .scan_done(hdone), .scan_hit(hhit), .scan_last(hlast));

   // Decode the latched action.
   always_comb begin
      is_enq = (act_ff <= 4'(ACT_ENQ_WRITER2));
      is_acq = (act_ff >= 4'(ACT_ACQ_READER)) && (act_ff <= 4'(ACT_ACQ_WRITER2));
      cls    = is_enq ? act_ff[1:0] : 2'(act_ff - 4'(ACT_ACQ_READER));
   end

   // Policy check for an acquire.
   always_comb begin
      grant = fmatch[cls];
      if (cls != 2'd1 && mode == MODE_WRITER1 && fne[1]) grant = 1'b0;
      if (cls != 2'd2 && mode == MODE_WRITER2 && fne[2]) grant = 1'b0;
      if (cls != 2'd0 && mode == MODE_READER  && fne[0]) grant = 1'b0;
      if (mode == MODE_NONE && !amatch) grant = 1'b0;
      if (cls == 2'd0) begin
         if (w1_ff || w2_ff) grant = 1'b0;
      end else if (w1_ff || w2_ff || hcount != '0) grant = 1'b0;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept_req) state_in = S_SCAN;
         S_SCAN: begin
            if (act_ff == 4'(ACT_UNLOCK) && !w1_ff && !w2_ff) begin
               if (hhit) state_in = S_SHIFT;
               else if (hdone) state_in = S_RESP;
            end else state_in = S_RESP;
         end
         // The shift that moves past the last slot also drops the count.
         S_SHIFT: if (hlast) state_in = S_RESP;
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: queue strobes, holder control and status.
   always_comb begin
      fpush = '0; fpop = '0; apush = 1'b0; apop = 1'b0;
      hctrl = '0;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: hctrl.clear_scan = 1'b1;
         S_SCAN: begin
            status_in = ST_OK;
            if (is_enq) begin
               if (ffull[cls] || afull) status_in = ST_FULL;
               else begin fpush[cls] = 1'b1; apush = 1'b1; end
            end else if (is_acq) begin
               if (!grant) status_in = ST_REFUSED;
               else if (cls == 2'd0 && hfull) status_in = ST_FULL;
               else begin
                  fpop[cls] = 1'b1; apop = 1'b1;
                  if (cls == 2'd0) hctrl.add = 1'b1;
               end
            end else if (act_ff == 4'(ACT_UNLOCK)) begin
               if (w1_ff) status_in = (w1_id_ff == tid_ff) ? ST_OK : ST_NOT_HOLDER;
               else if (w2_ff) status_in = (w2_id_ff == tid_ff) ? ST_OK : ST_NOT_HOLDER;
               else if (!hhit) begin
                  hctrl.step_scan = 1'b1;
                  status_in = ST_NOT_HOLDER;
               end
            end
         end
         S_SHIFT: hctrl.shift = 1'b1;
         S_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 2'(MODE_NONE);
         w1_ff        <= 1'b0;
         w2_ff        <= 1'b0;
         destroyed_ff <= 1'b0;
         status_ff    <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         if (csr_valid && csr_ready) mode_ff <= csr_data;
         if (state_ff == S_SCAN) begin
            if (is_acq && grant && cls == 2'd1) w1_ff <= 1'b1;
            if (is_acq && grant && cls == 2'd2) w2_ff <= 1'b1;
            if (act_ff == 4'(ACT_UNLOCK)) begin
               if (w1_ff) begin
                  if (w1_id_ff == tid_ff) w1_ff <= 1'b0;
               end else if (w2_ff && w2_id_ff == tid_ff) w2_ff <= 1'b0;
            end
            if (act_ff == 4'(ACT_INIT)) destroyed_ff <= 1'b0;
            if (act_ff == 4'(ACT_DESTROY)) destroyed_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept_req) begin
         act_ff <= req_tdata[3:0];
         tid_ff <= req_tdata[6:4];
      end
      if (state_ff == S_SCAN && is_acq && grant) begin
         if (cls == 2'd1) w1_id_ff <= tid_ff;
         if (cls == 2'd2) w2_id_ff <= tid_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {4'b0, destroyed_ff, fne[2], fne[1], fne[0],
                        4'(hcount), w2_ff, w1_ff, status_ff};
endmodule
`default_nettype wire

/* src/rwl2_checker.sv */
// Port-level checker for the lock manager, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none
module rwl2_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata
);
   // A response never shows both writer classes holding.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3])) else $error("two writers");
   // Writers and readers never hold together.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2] || rsp_tdata[3]) |-> rsp_tdata[7:4] == 4'd0)
      else $error("writer with readers");
   // No new request while a response is pending.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready during response");
   // A taken request yields no response in the very next cycle's edge.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid) else $error("early response");
   // A stalled response beat stays offered and unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
endmodule

bind rw_lock_two_writer_classes_unit rwl2_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);
`default_nettype wire

/* sim/tb_rw_lock_two_writer_classes_unit.sv */
// Self-checking testbench for the two-writer-class readers-writer lock manager.
// Depends on rwl2_pkg and rw_lock_two_writer_classes_unit; drives a directed
// table and random lock traffic and checks every response against a local model.
`timescale 1ns / 1ps
`default_nettype none
module tb_rw_lock_two_writer_classes_unit;
   import rwl2_pkg::*;

   localparam int Depth = 8;
   localparam int MaxHolds = 8;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic       destroyed;
      logic       w2_wait;
      logic       w1_wait;
      logic       rd_wait;
      logic [3:0] rd_count;
      logic       w2_held;
      logic       w1_held;
      status_type status;
   } lock_view_type;

   typedef struct {
      action_type    act;
      logic [2:0]    tid;
      logic          known;
      lock_view_type view;
   } lock_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   rw_lock_two_writer_classes_unit uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   // Local copy of the lock state.
   mode_type   pref_mode;
   logic [2:0] fq [3][$];
   logic [2:0] arrival_q [$];
   logic [2:0] reader_holds [$];
   logic       w1_valid, w2_valid, destroyed;
   logic [2:0] w1_tid, w2_tid;

   lock_view_type expected_views [$];
   int         errors = 0;
   int         cycles = 0;
   int         rsp_seen = 0;
   int         hold_off = 0;
   logic       long_stall_arm = 1'b0;
   logic       long_stall_used = 1'b0;
   int         refused_cnt = 0, granted_cnt = 0;

   function automatic logic front_is(input logic [2:0] q [$], input logic [2:0] tid);
      return q.size() > 0 && q[0] == tid;
   endfunction

   function automatic logic acquire_allowed(int cls, logic [2:0] tid);
      logic rw, w1, w2;
      rw = fq[0].size() > 0;
      w1 = fq[1].size() > 0;
      w2 = fq[2].size() > 0;
      if (cls != 1 && pref_mode == MODE_WRITER1 && w1) return 1'b0;
      if (cls != 2 && pref_mode == MODE_WRITER2 && w2) return 1'b0;
      if (cls != 0 && pref_mode == MODE_READER && rw) return 1'b0;
      if (pref_mode == MODE_NONE && !front_is(arrival_q, tid)) return 1'b0;
      if (!front_is(fq[cls], tid)) return 1'b0;
      if (cls == 0) return !(w1_valid || w2_valid);
      return !(w1_valid || w2_valid) && reader_holds.size() == 0;
   endfunction

   // Applies one request to the local state and returns the response it gives.
   function automatic lock_view_type predict_lock_view(logic [3:0] act, logic [2:0] tid);
      lock_view_type v;
      status_type st;
      int cls;
      int hit;
      st = ST_OK;
      if (act <= ACT_ENQ_WRITER2) begin
         cls = act;
         if (fq[cls].size() >= Depth || arrival_q.size() >= Depth) st = ST_FULL;
         else begin
            fq[cls].insert(fq[cls].size(), tid);
            arrival_q.insert(arrival_q.size(), tid);
         end
      end else if (act <= ACT_ACQ_WRITER2) begin
         cls = act - ACT_ACQ_READER;
         if (!acquire_allowed(cls, tid)) st = ST_REFUSED;
         else if (cls == 0 && reader_holds.size() >= MaxHolds) st = ST_FULL;
         else begin
            void'(fq[cls].pop_front());
            if (arrival_q.size() > 0) void'(arrival_q.pop_front());
            if (cls == 0) reader_holds.insert(reader_holds.size(), tid);
            else if (cls == 1) begin
               w1_valid = 1'b1;
               w1_tid = tid;
            end else begin
               w2_valid = 1'b1;
               w2_tid = tid;
            end
         end
      end else if (act == ACT_UNLOCK) begin
         st = ST_NOT_HOLDER;
         if (w1_valid) begin
            if (w1_tid == tid) begin
               w1_valid = 1'b0;
               st = ST_OK;
            end
         end else if (w2_valid) begin
            if (w2_tid == tid) begin
               w2_valid = 1'b0;
               st = ST_OK;
            end
         end else begin
            hit = -1;
            foreach (reader_holds[i]) if (hit < 0 && reader_holds[i] == tid) hit = i;
            if (hit >= 0) begin
               reader_holds.delete(hit);
               st = ST_OK;
            end
         end
      end else if (act == ACT_INIT) destroyed = 1'b0;
      else if (act == ACT_DESTROY) destroyed = 1'b1;
      v.status = st;
      v.w1_held = w1_valid;
      v.w2_held = w2_valid;
      v.rd_count = 4'(reader_holds.size());
      v.rd_wait = fq[0].size() > 0;
      v.w1_wait = fq[1].size() > 0;
      v.w2_wait = fq[2].size() > 0;
      v.destroyed = destroyed;
      if (st == ST_REFUSED) refused_cnt++;
      else if (act >= ACT_ACQ_READER && act <= ACT_ACQ_WRITER2 && st == ST_OK)
         granted_cnt++;
      return v;
   endfunction

   // The request stays offered after its beat when the next one follows at once.
   task automatic send_request(logic [3:0] act, logic [2:0] tid, logic known,
                               lock_view_type typed);
      lock_view_type v;
      lock_view_type e;
      int idle;
      idle = $urandom_range(0, 7);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tdata <= {1'b0, tid, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      v = predict_lock_view(act, tid);
      if (known && v != typed)
         $error("table row disagrees with model: typed %h model %h", typed, v);
      e = known ? typed : v;
      expected_views.insert(expected_views.size(), e);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (expected_views.size() > 0) @(posedge clock);
      repeat (2 * MaxHolds + 4) @(posedge clock);
   endtask

   task automatic write_mode(mode_type m);
      drain_responses();
      csr_data <= m;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pref_mode = m;
   endtask

   // Response side: random stalls plus one long hold-off once armed.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (long_stall_arm && !long_stall_used) begin
         long_stall_used <= 1'b1;
         hold_off <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(0, 7) < 5);
   end

   // Compare each accepted response beat with the oldest expectation.
   always @(posedge clock) begin
      lock_view_type got, exp_v;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[11:0];
         rsp_seen <= rsp_seen + 1;
         if (expected_views.size() == 0) begin
            $error("response beat with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            exp_v = expected_views.pop_front();
            if (got.status != exp_v.status) begin
               $error("status expected %0d actual %0d", exp_v.status, got.status); errors++; end
            if (got.w1_held != exp_v.w1_held) begin
               $error("writer1_held expected %0d actual %0d", exp_v.w1_held, got.w1_held); errors++; end
            if (got.w2_held != exp_v.w2_held) begin
               $error("writer2_held expected %0d actual %0d", exp_v.w2_held, got.w2_held); errors++; end
            if (got.rd_count != exp_v.rd_count) begin
               $error("reader_count expected %0d actual %0d", exp_v.rd_count, got.rd_count); errors++; end
            if (got.rd_wait != exp_v.rd_wait) begin
               $error("readers_waiting expected %0d actual %0d", exp_v.rd_wait, got.rd_wait); errors++; end
            if (got.w1_wait != exp_v.w1_wait) begin
               $error("writer1_waiting expected %0d actual %0d", exp_v.w1_wait, got.w1_wait); errors++; end
            if (got.w2_wait != exp_v.w2_wait) begin
               $error("writer2_waiting expected %0d actual %0d", exp_v.w2_wait, got.w2_wait); errors++; end
            if (got.destroyed != exp_v.destroyed) begin
               $error("lock_destroyed expected %0d actual %0d", exp_v.destroyed, got.destroyed); errors++; end
         end
      end
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Random traffic: mostly enqueue, acquire and unlock requests in random order.
   task automatic random_traffic(int n);
      logic [3:0] act;
      logic [2:0] tid;
      int cls;
      lock_view_type none;
      none = '0;
      for (int i = 0; i < n; i++) begin
         tid = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0, 1, 2: act = 4'($urandom_range(0, 2));
            3, 4, 5: begin
               // Acquire usually on behalf of a front-of-queue thread.
               cls = $urandom_range(0, 2);
               act = 4'(ACT_ACQ_READER + cls);
               if (fq[cls].size() > 0 && $urandom_range(0, 3) != 0) tid = fq[cls][0];
            end
            6, 7: begin
               act = ACT_UNLOCK;
               if (w1_valid && $urandom_range(0, 3) != 0) tid = w1_tid;
               else if (w2_valid && $urandom_range(0, 3) != 0) tid = w2_tid;
               else if (reader_holds.size() > 0 && $urandom_range(0, 3) != 0)
                  tid = reader_holds[$urandom_range(0, reader_holds.size() - 1)];
            end
            8: act = 4'($urandom_range(7, 8));
            default: act = 4'($urandom_range(0, 15));
         endcase
         send_request(act, tid, 1'b0, none);
      end
   endtask

   lock_row_type directed [$];

   function automatic lock_view_type vw(status_type s, logic w1, logic w2, int rc,
                                        logic rw, logic ww1, logic ww2, logic d);
      lock_view_type v;
      v.status = s; v.w1_held = w1; v.w2_held = w2; v.rd_count = 4'(rc);
      v.rd_wait = rw; v.w1_wait = ww1; v.w2_wait = ww2; v.destroyed = d;
      return v;
   endfunction

   function automatic void row(action_type a, int t, logic k, lock_view_type v);
      lock_row_type r;
      r.act = a; r.tid = 3'(t); r.known = k; r.view = v;
      directed.insert(directed.size(), r);
   endfunction

   initial begin
      lock_view_type z;
      z = '0;
      pref_mode = MODE_NONE;
      w1_valid = 0; w2_valid = 0; destroyed = 0; w1_tid = 0; w2_tid = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table: reset state, empty-front refusals, unlock by non-holder,
      // destroy/init, unused action, then queue-full and holder-full cases.
      row(ACT_ACQ_READER, 0, 1, vw(ST_REFUSED, 0, 0, 0, 0, 0, 0, 0));
      row(ACT_UNLOCK, 7, 1, vw(ST_NOT_HOLDER, 0, 0, 0, 0, 0, 0, 0));
      row(ACT_DESTROY, 0, 1, vw(ST_OK, 0, 0, 0, 0, 0, 0, 1));
      row(ACT_INIT, 0, 1, vw(ST_OK, 0, 0, 0, 0, 0, 0, 0));
      row(action_type'(4'd15), 7, 1, vw(ST_OK, 0, 0, 0, 0, 0, 0, 0));
      row(ACT_ENQ_WRITER1, 7, 1, vw(ST_OK, 0, 0, 0, 0, 1, 0, 0));
      row(ACT_ACQ_WRITER1, 7, 1, vw(ST_OK, 1, 0, 0, 0, 0, 0, 0));
      row(ACT_UNLOCK, 3, 1, vw(ST_NOT_HOLDER, 1, 0, 0, 0, 0, 0, 0));
      row(ACT_UNLOCK, 7, 1, vw(ST_OK, 0, 0, 0, 0, 0, 0, 0));
      row(ACT_ENQ_WRITER2, 0, 0, z);
      row(ACT_ACQ_WRITER2, 0, 0, z);
      row(ACT_UNLOCK, 0, 0, z);
      for (int t = 0; t < 8; t++) row(ACT_ENQ_READER, t, 0, z);
      row(ACT_ENQ_READER, 5, 1, vw(ST_FULL, 0, 0, 0, 1, 0, 0, 0));
      for (int t = 0; t < 8; t++) row(ACT_ACQ_READER, t, 0, z);
      foreach (directed[i])
         send_request(directed[i].act, directed[i].tid, directed[i].known,
                      directed[i].view);
      // Full holder list: ninth reader passes the check but is refused as full.
      send_request(ACT_ENQ_READER, 6, 1'b0, z);
      send_request(ACT_ACQ_READER, 6, 1'b1, vw(ST_FULL, 0, 0, 8, 1, 0, 0, 0));
      for (int t = 7; t >= 0; t--) send_request(ACT_UNLOCK, 3'(t), 1'b0, z);

      // Sweep all modes, extremes included, with random traffic under each.
      for (int m = 0; m < 4; m++) begin
         write_mode(mode_type'(m));
         random_traffic(250);
         if (m == 1) begin
            long_stall_arm = 1'b1;
            random_traffic(30);
         end
      end
      write_mode(MODE_WRITER2);
      random_traffic(150);
      write_mode(MODE_NONE);
      random_traffic(100);

      drain_responses();
      $display("Checked %0d responses over all four preference modes: %0d grants, %0d refusals.",
               rsp_seen, granted_cnt, refused_cnt);
      if (errors == 0 && expected_views.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
